// File: rtl/core/heia_pkg.sv
// Package for the hashed event id allocator.
// Holds the request, status and register codes and the reset range that the core and its environment share.
// No dependencies.
package heia_pkg;

	localparam logic [1:0] REQ_ALLOC    = 2'd0;
	localparam logic [1:0] REQ_FREE     = 2'd1;
	localparam logic [1:0] REQ_DISPATCH = 2'd2;
	localparam logic [1:0] REQ_NOP      = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFREE   = 2'd1;
	localparam logic [1:0] ST_NOTALLOC = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	localparam logic [15:0] FIRST_RESET = 16'h2000;
	localparam logic [15:0] LAST_RESET  = 16'h4000;

	localparam logic REG_FIRST = 1'b0;
	localparam logic REG_LAST  = 1'b1;

endpackage

// File: rtl/core/hashed_event_id_allocator.sv
// Hashed event id allocator: one sequencer over the allocation map, tag and bin occupancy memories.
// Uses heia_pkg for request, status and register codes.
//
// Sequence: a no-op or out-of-range request goes straight to the result state; dispatch reads the
// map and tag memories; free also finds the bin index (reciprocal multiply, then one multiply-subtract)
// and lowers that bin's occupancy; allocate runs an issue and a check state per bin or map word probed.
// One request at a time: busy stays high until the result strobe; done pulses for one cycle.
// After reset a clearing pass over max(ID_SPACE, NUM_BINS) entries runs with busy high.
module hashed_event_id_allocator #(
	parameter int NUM_BINS = 256,
	parameter int ID_SPACE = 16384
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] event_id,
	input  logic        wants_callback,
	input  logic [31:0] context_tag,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] result_id,
	output logic        notify,
	output logic [31:0] handler_tag,
	output logic [14:0] live_count,
	output logic [14:0] peak_count
);

	localparam int OFFW = $clog2(ID_SPACE);
	localparam int BINW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CW   = $clog2(ID_SPACE + 1);
	localparam int SW   = $clog2(ID_SPACE + NUM_BINS + 1);
	localparam int OW   = $clog2(ID_SPACE / NUM_BINS + 2);
	localparam int CLRN = (ID_SPACE > NUM_BINS) ? ID_SPACE : NUM_BINS;
	localparam int QS   = OFFW + BINW;
	localparam int RW   = OFFW + 2;
	localparam int PRW  = OFFW + RW;
	localparam int PW   = OFFW + BINW + 1;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << QS) + 64'(NUM_BINS) - 64'd1) / 64'(NUM_BINS));

	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_AISSUE  = 4'd2;
	localparam logic [3:0] S_ACHECK  = 4'd3;
	localparam logic [3:0] S_ADONE   = 4'd4;
	localparam logic [3:0] S_MISSUE  = 4'd5;
	localparam logic [3:0] S_MCHECK  = 4'd6;
	localparam logic [3:0] S_MOD     = 4'd7;
	localparam logic [3:0] S_OISSUE  = 4'd8;
	localparam logic [3:0] S_OCHECK  = 4'd9;
	localparam logic [3:0] S_FINISH  = 4'd10;

	logic [3:0]  state_q;
	logic [15:0] first_q, last_q;
	logic [SW-1:0] clr_q;

	logic [1:0]  req_q;
	logic        cb_q;
	logic [31:0] tag_q;
	logic [CW-1:0] n_q;
	logic [OFFW-1:0] off_q;

	logic [SW-1:0] b_q, o_q;
	logic        found_q;
	logic [OFFW-1:0] best_off_q;
	logic [BINW-1:0] best_bin_q;
	logic [OW-1:0]   best_occ_q;
	logic [OFFW-1:0] r_q;
	logic [OFFW-1:0] quo_q;

	logic [CW-1:0] live_q, peak_q;

	logic        done_q;
	logic [1:0]  status_q;
	logic [15:0] rid_q;
	logic        notify_q;
	logic [31:0] htag_q;

	// Allocation map entry: bit 1 allocated, bit 0 handler attached.
	logic [1:0]  map_mem [ID_SPACE];
	logic [31:0] tag_mem [ID_SPACE];
	logic [OW-1:0] occ_mem [NUM_BINS];
	logic [1:0]  map_rd;
	logic [31:0] tag_rd;
	logic [OW-1:0] occ_rd;

	logic        map_we, tag_we, occ_we;
	logic [OFFW-1:0] map_wa, map_ra;
	logic [1:0]  map_wd;
	logic [BINW-1:0] occ_wa, occ_ra;
	logic [OW-1:0]   occ_wd;

	// Range in use from the current registers.
	logic [17:0] lim, hi, n_full, id_rel;
	logic [CW-1:0] n_now;
	logic        in_range;
	logic        accept, cfg_wr;

	always_comb begin
		lim = {2'b00, first_q} + 18'(ID_SPACE) - 18'd1;
		hi = ({2'b00, last_q} < lim) ? {2'b00, last_q} : lim;
		n_full = (hi < {2'b00, first_q}) ? 18'd0 : hi - {2'b00, first_q} + 18'd1;
		n_now = CW'(n_full);
		id_rel = {2'b00, event_id} - {2'b00, first_q};
		in_range = (event_id >= first_q) && (id_rel < n_full);
	end

	assign accept = start && (state_q == S_IDLE);
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == heia_pkg::REG_LAST) ? {16'd0, last_q} : {16'd0, first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= heia_pkg::FIRST_RESET;
			last_q <= heia_pkg::LAST_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == heia_pkg::REG_LAST) begin
				last_q <= pwdata[15:0];
			end else begin
				first_q <= pwdata[15:0];
			end
		end
	end

	// Scan helpers.
	logic [SW-1:0]  o_next, b_next;
	logic           bin_head;
	logic [PRW-1:0] quo_prod;
	logic [PW-1:0]  bin_base;

	// The bin of an offset is the offset minus its quotient times NUM_BINS. The quotient
	// comes from a multiply by the rounded-up reciprocal, exact over the whole offset range.
	always_comb begin
		o_next = o_q + SW'(NUM_BINS);
		b_next = b_q + SW'(1);
		bin_head = (o_q == b_q);
		quo_prod = PRW'(off_q) * PRW'(RECIP);
		bin_base = PW'(quo_q) * PW'(NUM_BINS);
	end

	// Memory port control.
	always_comb begin
		map_we = 1'b0;
		map_wa = best_off_q;
		map_wd = 2'b00;
		tag_we = 1'b0;
		occ_we = 1'b0;
		occ_wa = best_bin_q;
		occ_wd = best_occ_q + OW'(1);
		map_ra = (state_q == S_AISSUE) ? o_q[OFFW-1:0] : off_q;
		occ_ra = (state_q == S_AISSUE) ? b_q[BINW-1:0] : BINW'(r_q);
		unique case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
				map_wa = clr_q[OFFW-1:0];
				occ_we = clr_q < SW'(NUM_BINS);
				occ_wa = clr_q[BINW-1:0];
				occ_wd = '0;
			end
			S_ADONE: begin
				map_we = found_q;
				map_wd = {1'b1, cb_q};
				tag_we = found_q;
				occ_we = found_q;
			end
			S_MCHECK: begin
				map_we = (req_q == heia_pkg::REQ_FREE) && map_rd[1];
				map_wa = off_q;
			end
			S_OCHECK: begin
				occ_we = 1'b1;
				occ_wa = BINW'(r_q);
				occ_wd = (occ_rd != '0) ? occ_rd - OW'(1) : occ_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd <= map_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[best_off_q] <= tag_q;
		end
		tag_rd <= tag_mem[map_ra];
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		occ_rd <= occ_mem[occ_ra];
	end

	// Request payload and scan registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			cb_q <= wants_callback;
			tag_q <= context_tag;
			n_q <= n_now;
			off_q <= OFFW'(id_rel);
			b_q <= '0;
			o_q <= '0;
		end
		unique case (state_q)
			S_ACHECK: begin
				if (!(bin_head && found_q && occ_rd >= best_occ_q) && !map_rd[1]) begin
					best_off_q <= o_q[OFFW-1:0];
					best_bin_q <= b_q[BINW-1:0];
					best_occ_q <= occ_rd;
					b_q <= b_next;
					o_q <= b_next;
				end else if (!(bin_head && found_q && occ_rd >= best_occ_q)
						&& (o_next < SW'(n_q))) begin
					o_q <= o_next;
				end else begin
					b_q <= b_next;
					o_q <= b_next;
				end
			end
			S_MCHECK: begin
				quo_q <= OFFW'(quo_prod >> QS);
			end
			S_MOD: begin
				r_q <= OFFW'(PW'(off_q) - bin_base);
			end
			default: begin
			end
		endcase
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			found_q <= 1'b0;
			live_q <= '0;
			peak_q <= '0;
			done_q <= 1'b0;
			status_q <= heia_pkg::ST_OK;
			rid_q <= '0;
			notify_q <= 1'b0;
			htag_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SW'(1);
					if (clr_q == SW'(CLRN - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						status_q <= heia_pkg::ST_OK;
						rid_q <= event_id;
						notify_q <= 1'b0;
						htag_q <= '0;
						found_q <= 1'b0;
						state_q <= S_FINISH;
						case (req_type)
							heia_pkg::REQ_ALLOC: begin
								rid_q <= '0;
								if (n_now == '0) begin
									status_q <= heia_pkg::ST_NOFREE;
								end else begin
									state_q <= S_AISSUE;
								end
							end
							heia_pkg::REQ_FREE, heia_pkg::REQ_DISPATCH: begin
								if (!in_range) begin
									status_q <= heia_pkg::ST_RANGE;
								end else begin
									state_q <= S_MISSUE;
								end
							end
							default: begin
								rid_q <= '0;
							end
						endcase
					end
				end
				S_AISSUE: state_q <= S_ACHECK;
				S_ACHECK: begin
					if (!(bin_head && found_q && occ_rd >= best_occ_q) && !map_rd[1]) begin
						found_q <= 1'b1;
						state_q <= (b_next < SW'(NUM_BINS) && b_next < SW'(n_q))
							? S_AISSUE : S_ADONE;
					end else if (!(bin_head && found_q && occ_rd >= best_occ_q)
							&& (o_next < SW'(n_q))) begin
						state_q <= S_AISSUE;
					end else begin
						state_q <= (b_next < SW'(NUM_BINS) && b_next < SW'(n_q))
							? S_AISSUE : S_ADONE;
					end
				end
				S_ADONE: begin
					if (found_q) begin
						live_q <= live_q + CW'(1);
						if (live_q + CW'(1) > peak_q) begin
							peak_q <= live_q + CW'(1);
						end
						rid_q <= first_q + 16'(best_off_q);
					end else begin
						status_q <= heia_pkg::ST_NOFREE;
					end
					state_q <= S_FINISH;
				end
				S_MISSUE: state_q <= S_MCHECK;
				S_MCHECK: begin
					state_q <= S_FINISH;
					if (!map_rd[1]) begin
						status_q <= heia_pkg::ST_NOTALLOC;
					end else if (req_q == heia_pkg::REQ_FREE) begin
						state_q <= S_MOD;
					end else if (map_rd[0]) begin
						notify_q <= 1'b1;
						htag_q <= tag_rd;
					end
				end
				S_MOD: state_q <= S_OISSUE;
				S_OISSUE: state_q <= S_OCHECK;
				S_OCHECK: begin
					if (live_q != '0) begin
						live_q <= live_q - CW'(1);
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign result_id = rid_q;
	assign notify = notify_q;
	assign handler_tag = htag_q;
	assign live_count = 15'(live_q);
	assign peak_count = 15'(peak_q);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held longer than one cycle");
	a_live_le_peak: assert property (@(posedge clk) disable iff (!arst_n) live_q <= peak_q)
		else $error("live count above peak count");
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");
	a_notify_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && notify) |-> (status == heia_pkg::ST_OK))
		else $error("notify raised on a failed request");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the hashed event id allocator.
// Drives requests through start/busy and registers through the APB port, and checks every
// done strobe against a built-in prediction. Depends on heia_pkg and the RTL top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BINS = 256;
	localparam int IDS  = 16384;

	typedef struct {
		logic [1:0]  req;
		logic [15:0] id;
		logic        cb;
		logic [31:0] tag;
	} event_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] rid;
		logic        notify;
		logic [31:0] htag;
		logic [14:0] live;
		logic [14:0] peak;
	} event_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = heia_pkg::REQ_NOP;
	logic [15:0] event_id = '0;
	logic wants_callback = 1'b0;
	logic [31:0] context_tag = '0;
	logic done;
	logic [1:0] status;
	logic [15:0] result_id;
	logic notify;
	logic [31:0] handler_tag;
	logic [14:0] live_count, peak_count;

	hashed_event_id_allocator dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow of the block's state.
	bit          used_map [IDS];
	bit          cb_map   [IDS];
	logic [31:0] tag_mem  [IDS];
	int unsigned bin_occ  [BINS];
	int unsigned live_cnt, peak_cnt;
	int unsigned first_ev = heia_pkg::FIRST_RESET, last_ev = heia_pkg::LAST_RESET;

	event_req_t  pending_reqs[$];
	event_resp_t expected_resps[$];
	int idle_pct = 0;
	int errors = 0, checked = 0, notifies = 0, exhausted = 0, cfg_writes = 0;

	function automatic int unsigned managed_count();
		int unsigned hi, lim;
		hi = last_ev;
		lim = first_ev + IDS - 1;
		if (hi > lim) hi = lim;
		if (hi < first_ev) return 0;
		return hi - first_ev + 1;
	endfunction

	function automatic event_resp_t apply_request(event_req_t r);
		event_resp_t e;
		int unsigned n, off, best_bin, best_off, best_occ;
		bit found, in_range;
		e = '{status: heia_pkg::ST_OK, rid: '0, notify: 1'b0, htag: '0, live: '0, peak: '0};
		n = managed_count();
		in_range = (r.id >= first_ev) && (r.id - first_ev < n);
		off = r.id - first_ev;
		found = 0;
		best_bin = 0; best_off = 0; best_occ = 0;
		case (r.req)
			heia_pkg::REQ_ALLOC: begin
				for (int unsigned b = 0; b < BINS && b < n; b++) begin
					if (found && bin_occ[b] >= best_occ) continue;
					for (int unsigned o = b; o < n; o += BINS) begin
						if (!used_map[o]) begin
							found = 1; best_bin = b; best_off = o; best_occ = bin_occ[b];
							break;
						end
					end
				end
				if (!found) begin
					e.status = heia_pkg::ST_NOFREE;
				end else begin
					used_map[best_off] = 1;
					cb_map[best_off] = r.cb;
					tag_mem[best_off] = r.tag;
					bin_occ[best_bin]++;
					live_cnt++;
					if (live_cnt > peak_cnt) peak_cnt = live_cnt;
					e.rid = 16'(first_ev + best_off);
				end
			end
			heia_pkg::REQ_FREE: begin
				e.rid = r.id;
				if (!in_range) e.status = heia_pkg::ST_RANGE;
				else if (!used_map[off]) e.status = heia_pkg::ST_NOTALLOC;
				else begin
					used_map[off] = 0;
					cb_map[off] = 0;
					if (bin_occ[off % BINS] > 0) bin_occ[off % BINS]--;
					if (live_cnt > 0) live_cnt--;
				end
			end
			heia_pkg::REQ_DISPATCH: begin
				e.rid = r.id;
				if (!in_range) e.status = heia_pkg::ST_RANGE;
				else if (!used_map[off]) e.status = heia_pkg::ST_NOTALLOC;
				else if (cb_map[off]) begin
					e.notify = 1'b1;
					e.htag = tag_mem[off];
				end
			end
			default: ;
		endcase
		e.live = 15'(live_cnt);
		e.peak = 15'(peak_cnt);
		return e;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	// Driver: a request stays on the ports until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			bit taken;
			taken = start && !busy;
			if (taken) begin
				expected_resps.push_back(apply_request(pending_reqs.pop_front()));
			end
			if (!start || taken) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					req_type <= pending_reqs[0].req;
					event_id <= pending_reqs[0].id;
					wants_callback <= pending_reqs[0].cb;
					context_tag <= pending_reqs[0].tag;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_resps.size() == 0) begin
				report_mismatch("result with no request waiting", result_id, 0);
			end else begin
				event_resp_t e;
				e = expected_resps.pop_front();
				checked++;
				if (e.notify) notifies++;
				if (e.status == heia_pkg::ST_NOFREE) exhausted++;
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (result_id !== e.rid) report_mismatch("result_id", result_id, e.rid);
				if (notify !== e.notify) report_mismatch("notify", notify, e.notify);
				if (handler_tag !== e.htag) report_mismatch("handler_tag", handler_tag, e.htag);
				if (live_count !== e.live) report_mismatch("live_count", live_count, e.live);
				if (peak_count !== e.peak) report_mismatch("peak_count", peak_count, e.peak);
			end
		end
	end

	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_resps.size() > 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic sel, int unsigned value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {sel, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (sel == heia_pkg::REG_FIRST) first_ev = value & 16'hFFFF;
		else last_ev = value & 16'hFFFF;
		cfg_writes++;
	endtask

	task automatic push_req(logic [1:0] r, logic [15:0] id, logic cb, logic [31:0] tag);
		pending_reqs.push_back('{req: r, id: id, cb: cb, tag: tag});
	endtask

	// Random requests, mostly against numbers inside the current range.
	task automatic push_random(int count);
		int unsigned n;
		logic [15:0] id;
		int k;
		n = managed_count();
		repeat (count) begin
			if (n > 0 && $urandom_range(99) < 80) id = 16'(first_ev + $urandom_range(n - 1));
			else id = 16'($urandom);
			k = $urandom_range(99);
			if (k < 40) push_req(heia_pkg::REQ_ALLOC, 16'($urandom), 1'($urandom), $urandom);
			else if (k < 67) push_req(heia_pkg::REQ_FREE, id, 1'($urandom), $urandom);
			else if (k < 95) push_req(heia_pkg::REQ_DISPATCH, id, 1'($urandom), $urandom);
			else push_req(heia_pkg::REQ_NOP, 16'($urandom), 1'($urandom), $urandom);
		end
	endtask

	initial begin
		int unsigned f;
		int idle_modes[3];
		idle_modes = '{0, 56, 36};
		foreach (used_map[i]) begin
			used_map[i] = 0; cb_map[i] = 0; tag_mem[i] = '0;
		end
		foreach (bin_occ[i]) bin_occ[i] = 0;
		live_cnt = 0; peak_cnt = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed part at the reset range.
		push_req(heia_pkg::REQ_ALLOC, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		push_req(heia_pkg::REQ_ALLOC, 16'h0000, 1'b0, 32'h0000_0000);
		push_req(heia_pkg::REQ_DISPATCH, heia_pkg::FIRST_RESET, 1'b0, '0);
		push_req(heia_pkg::REQ_DISPATCH, heia_pkg::FIRST_RESET + 16'd1, 1'b0, '0);
		push_req(heia_pkg::REQ_DISPATCH, heia_pkg::FIRST_RESET + 16'd2, 1'b0, '0);
		push_req(heia_pkg::REQ_DISPATCH, heia_pkg::FIRST_RESET - 16'd1, 1'b0, '0);
		push_req(heia_pkg::REQ_DISPATCH, heia_pkg::LAST_RESET, 1'b0, '0);
		push_req(heia_pkg::REQ_FREE, heia_pkg::LAST_RESET + 16'd1, 1'b0, '0);
		push_req(heia_pkg::REQ_FREE, heia_pkg::FIRST_RESET, 1'b1, '1);
		push_req(heia_pkg::REQ_FREE, heia_pkg::FIRST_RESET, 1'b0, '0);
		push_req(heia_pkg::REQ_DISPATCH, heia_pkg::FIRST_RESET, 1'b0, '0);
		push_req(heia_pkg::REQ_FREE, 16'h0000, 1'b0, '0);
		push_req(heia_pkg::REQ_FREE, 16'hFFFF, 1'b0, '0);
		push_req(heia_pkg::REQ_NOP, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
		drain();

		// A single number at the top of the id space.
		write_reg(heia_pkg::REG_FIRST, 32'hFFFF);
		write_reg(heia_pkg::REG_LAST, 32'hFFFF);
		push_req(heia_pkg::REQ_ALLOC, '0, 1'b1, 32'hA5A5_5A5A);
		push_req(heia_pkg::REQ_ALLOC, '0, 1'b1, 32'h1234_5678);
		push_req(heia_pkg::REQ_DISPATCH, 16'hFFFF, 1'b0, '0);
		push_req(heia_pkg::REQ_FREE, 16'hFFFF, 1'b0, '0);
		push_req(heia_pkg::REQ_DISPATCH, 16'hFFFE, 1'b0, '0);
		drain();

		// Empty range: last below first.
		write_reg(heia_pkg::REG_LAST, 32'h0000);
		push_req(heia_pkg::REQ_ALLOC, '0, 1'b1, '1);
		push_req(heia_pkg::REQ_DISPATCH, 16'h0000, 1'b0, '0);
		push_req(heia_pkg::REQ_FREE, 16'hFFFF, 1'b0, '0);
		drain();

		// Full id space with last clipped by the id space size.
		write_reg(heia_pkg::REG_FIRST, 32'h0000);
		write_reg(heia_pkg::REG_LAST, 32'hFFFF);
		idle_pct = 56;
		push_random(40);
		drain();

		// Small random ranges so that bins fill up and run dry.
		for (int ph = 0; ph < 6; ph++) begin
			f = $urandom_range(16'hFFFF);
			write_reg(heia_pkg::REG_FIRST, f);
			write_reg(heia_pkg::REG_LAST, (f + $urandom_range(600) > 16'hFFFF) ? 16'hFFFF
				: f + $urandom_range(600));
			idle_pct = idle_modes[ph % 3];
			push_random(120);
			drain();
		end

		// First register back at its reset value, with a small range of 41 numbers from there.
		write_reg(heia_pkg::REG_FIRST, heia_pkg::FIRST_RESET);
		write_reg(heia_pkg::REG_LAST, heia_pkg::FIRST_RESET + 40);
		idle_pct = 0;
		push_random(40);
		drain();
		repeat (20) @(posedge clk);

		$display("Checked %0d results over %0d register writes: %0d notifications, %0d exhausted",
			checked, cfg_writes, notifies, exhausted);
		$display("allocations; final live count %0d, peak %0d.", live_cnt, peak_cnt);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("Timeout with %0d requests still expected.", expected_resps.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// File: hashed_event_id_allocator.f
rtl/core/heia_pkg.sv
rtl/core/hashed_event_id_allocator.sv
verif/tb.sv
